[rtl/etl_pkg.sv]
// etl_pkg: shared types, codes and the control store of the tween timeline
// depends on nothing; used by etl_useq and eased_tween_timeline_unit
`timescale 1ns / 1ps

package etl_pkg;

   localparam int CSR_IDX_W = 3;
   localparam int STEP_W    = 4;
   localparam int STEP_COUNT = 10;

   localparam logic [17:0] ELAPSED_MAX = 18'h1FFFF;

   typedef enum logic [2:0] {
      REG_DURATION  = 3'd0,
      REG_DELAY     = 3'd1,
      REG_EASE_MODE = 3'd2,
      REG_LOOP      = 3'd3,
      REG_FROM_X    = 3'd4,
      REG_TO_X      = 3'd5,
      REG_FROM_Y    = 3'd6,
      REG_TO_Y      = 3'd7
   } etl_reg_type;

   typedef enum logic [2:0] {
      OP_TICK   = 3'd0,
      OP_START  = 3'd1,
      OP_STOP   = 3'd2,
      OP_PAUSE  = 3'd3,
      OP_RESUME = 3'd4
   } etl_op_type;

   typedef enum logic [1:0] {
      EASE_LINEAR      = 2'd0,
      EASE_QUAD_IN     = 2'd1,
      EASE_QUAD_OUT    = 2'd2,
      EASE_QUAD_IN_OUT = 2'd3
   } etl_ease_type;

   typedef struct packed {
      logic [2:0]  op;
      logic [15:0] dt;
   } etl_req_type;

   typedef struct packed {
      logic signed [15:0] value_x;
      logic signed [15:0] value_y;
      logic               applied;
      logic [16:0]        eased_progress;
      logic               playing;
      logic               finished;
      logic               complete;
   } etl_rsp_type;

   // datapath operation of one control word
   typedef enum logic [3:0] {
      UOP_ADD   = 4'd0,
      UOP_CHECK = 4'd1,
      UOP_DIV   = 4'd2,
      UOP_EMUL  = 4'd3,
      UOP_SHAPE = 4'd4,
      UOP_MULX  = 4'd5,
      UOP_VALX  = 4'd6,
      UOP_MULY  = 4'd7,
      UOP_VALY  = 4'd8,
      UOP_DONE  = 4'd9
   } etl_uop_type;

   typedef enum logic [1:0] {
      JMP_NONE = 2'd0,
      JMP_NEG  = 2'd1,
      JMP_FULL = 2'd2,
      JMP_LOOP = 2'd3
   } etl_jmp_type;

   typedef logic [STEP_W-1:0] etl_step_type;

   localparam etl_step_type STEP_DIV  = 4'd2;
   localparam etl_step_type STEP_EMUL = 4'd3;
   localparam etl_step_type STEP_DONE = 4'd9;

   typedef struct packed {
      etl_uop_type  uop;
      etl_jmp_type  jmp;
      etl_step_type target;
   } etl_cw_type;

   typedef struct packed {
      logic neg;
      logic full;
      logic div_more;
   } etl_cond_type;

   localparam etl_cw_type UCODE [STEP_COUNT] = '{
      '{uop: UOP_ADD,   jmp: JMP_NEG,  target: STEP_DONE},
      '{uop: UOP_CHECK, jmp: JMP_FULL, target: STEP_EMUL},
      '{uop: UOP_DIV,   jmp: JMP_LOOP, target: STEP_DIV},
      '{uop: UOP_EMUL,  jmp: JMP_NONE, target: STEP_DONE},
      '{uop: UOP_SHAPE, jmp: JMP_NONE, target: STEP_DONE},
      '{uop: UOP_MULX,  jmp: JMP_NONE, target: STEP_DONE},
      '{uop: UOP_VALX,  jmp: JMP_NONE, target: STEP_DONE},
      '{uop: UOP_MULY,  jmp: JMP_NONE, target: STEP_DONE},
      '{uop: UOP_VALY,  jmp: JMP_NONE, target: STEP_DONE},
      '{uop: UOP_DONE,  jmp: JMP_NONE, target: STEP_DONE}
   };

endpackage

[rtl/etl_useq.sv]
// etl_useq: step counter and control store fetch with conditional jumps
// depends on etl_pkg for the control word, condition struct and program
`timescale 1ns / 1ps

module etl_useq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  launch,
   input  logic                  hold,
   input  etl_pkg::etl_cond_type cond,
   output etl_pkg::etl_cw_type   cw,
   output logic                  running
);
   import etl_pkg::*;

   etl_step_type step_ff, step_in;
   logic         run_ff, run_in;
   logic         taken;

   assign cw      = UCODE[step_ff];
   assign running = run_ff;

   always_comb begin
      unique case (cw.jmp)
         JMP_NONE: taken = 1'b0;
         JMP_NEG:  taken = cond.neg;
         JMP_FULL: taken = cond.full;
         JMP_LOOP: taken = cond.div_more;
         default:  taken = 1'b0;
      endcase
   end

   always_comb begin
      step_in = step_ff;
      run_in  = run_ff;
      if (launch) begin
         step_in = '0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         if (cw.uop == UOP_DONE) begin
            if (!hold) begin
               run_in  = 1'b0;
               step_in = '0;
            end
         end else if (taken) begin
            step_in = cw.target;
         end else begin
            step_in = step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         run_ff  <= 1'b0;
      end else begin
         step_ff <= step_in;
         run_ff  <= run_in;
      end
   end

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      run_ff |-> (step_ff < STEP_W'(STEP_COUNT)))
      else $error("step counter outside program");

endmodule

[rtl/eased_tween_timeline_unit.sv]
// eased_tween_timeline_unit: two-channel eased ramp engine, datapath and flags
// depends on etl_pkg and etl_useq
`timescale 1ns / 1ps

// Input words on req_ (valid/ready) carry an op and a dt: tick, start, stop,
// pause or resume. Every word gives exactly one result word on rsp_.
// Configuration is written through csr_we/csr_idx/csr_wdata while idle.
// Control words and ticks that do nothing load the result register at the
// accepting edge, so their result is valid the next cycle.
// A tick on a running timeline steps through the control store:
// elapsed add, range check, a restoring divider giving one quotient bit per
// cycle, then the shared multiplier for the easing curve and each channel.
// Full progress skips the divider, and a tick still in the delay goes from
// the elapsed add straight to the result. One word is in flight at a time.
// Reset clears flags, elapsed count, configuration and the result valid bit.
// When the receiver stalls the result word holds and no new word is taken
// until the pending one is drained; a tick only starts once the result
// register is free, so its last step never waits.
module eased_tween_timeline_unit #(
   parameter int FRAC_BITS   = 16,
   parameter int VALUE_WIDTH = 16,
   parameter int CSR_W       = (VALUE_WIDTH > 16) ? VALUE_WIDTH : 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  etl_pkg::etl_req_type              req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output etl_pkg::etl_rsp_type              rsp_data,
   input  logic                              csr_we,
   input  logic [etl_pkg::CSR_IDX_W-1:0]     csr_idx,
   input  logic [CSR_W-1:0]                  csr_wdata
);
   import etl_pkg::*;

   localparam int EW    = FRAC_BITS + 1;
   localparam int MA_W  = (VALUE_WIDTH + 1 > FRAC_BITS + 2) ? VALUE_WIDTH + 1 : FRAC_BITS + 2;
   localparam int MB_W  = FRAC_BITS + 3;
   localparam int PW    = MA_W + MB_W;
   localparam int CNT_W = $clog2(FRAC_BITS + 1);

   localparam logic [EW-1:0]        ONE_FX  = EW'(1) << FRAC_BITS;
   localparam logic [EW-1:0]        HALF_FX = EW'(1) << (FRAC_BITS - 1);
   localparam logic [FRAC_BITS+1:0] TWO_FX  = (FRAC_BITS + 2)'(1) << (FRAC_BITS + 1);
   localparam logic [PW-1:0]        RND     = PW'(1) << (FRAC_BITS - 1);

   // configuration
   logic [15:0]             dur_ff, delay_ff;
   etl_ease_type            mode_ff;
   logic                    loop_ff;
   logic [VALUE_WIDTH-1:0]  from_x_ff, to_x_ff, from_y_ff, to_y_ff;

   // timeline state and datapath
   logic signed [17:0]      elapsed_ff, elapsed_in;
   logic                    playing_ff, playing_in;
   logic                    finished_ff, finished_in;
   logic [15:0]             dt_ff;
   logic [EW-1:0]           t_ff, e_ff;
   logic [15:0]             rem_ff;
   logic [CNT_W-1:0]        count_ff;
   logic                    full_ff, applied_ff;
   logic signed [PW-1:0]    prod_ff;
   logic [VALUE_WIDTH-1:0]  vx_ff, vy_ff;
   logic                    rsp_valid_ff;
   etl_rsp_type             rsp_ff, rsp_in;
   logic                    rsp_load;

   etl_cw_type              cw;
   etl_cond_type            cond;
   logic                    running, launch, hold, accept;

   logic signed [18:0]      el_sum;
   logic [17:0]             el_sat;
   logic [16:0]             rem2;
   logic                    div_ge;
   logic                    upper_half;
   logic [FRAC_BITS+1:0]    two_minus_t;
   logic signed [MA_W-1:0]  mul_a;
   logic signed [MB_W-1:0]  mul_b;
   logic signed [PW-1:0]    product, shaped, rounded, q_val;
   logic signed [VALUE_WIDTH:0] diff_x, diff_y;
   logic [EW+15:0]          ep_wide;
   logic [VALUE_WIDTH-1:0]  from_sel;

   assign accept    = req_valid && req_ready;
   assign req_ready = !running && (!rsp_valid_ff || rsp_ready);
   assign launch    = accept && (req_data.op == OP_TICK) && playing_ff && !finished_ff;
   assign hold      = rsp_valid_ff && !rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   etl_useq u_useq (
      .clock   (clock),
      .reset   (reset),
      .launch  (launch),
      .hold    (hold),
      .cond    (cond),
      .cw      (cw),
      .running (running)
   );

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         dur_ff    <= '0;
         delay_ff  <= '0;
         mode_ff   <= EASE_LINEAR;
         loop_ff   <= 1'b0;
         from_x_ff <= '0;
         to_x_ff   <= '0;
         from_y_ff <= '0;
         to_y_ff   <= '0;
      end else if (csr_we) begin
         unique case (etl_reg_type'(csr_idx))
            REG_DURATION:  dur_ff    <= csr_wdata[15:0];
            REG_DELAY:     delay_ff  <= csr_wdata[15:0];
            REG_EASE_MODE: mode_ff   <= etl_ease_type'(csr_wdata[1:0]);
            REG_LOOP:      loop_ff   <= csr_wdata[0];
            REG_FROM_X:    from_x_ff <= csr_wdata[VALUE_WIDTH-1:0];
            REG_TO_X:      to_x_ff   <= csr_wdata[VALUE_WIDTH-1:0];
            REG_FROM_Y:    from_y_ff <= csr_wdata[VALUE_WIDTH-1:0];
            REG_TO_Y:      to_y_ff   <= csr_wdata[VALUE_WIDTH-1:0];
            default:       dur_ff    <= dur_ff;
         endcase
      end
   end

   // saturating elapsed add
   assign el_sum = {elapsed_ff[17], elapsed_ff} + $signed({3'b000, dt_ff});
   assign el_sat = (el_sum[18:17] == 2'b01) ? ELAPSED_MAX : el_sum[17:0];

   // restoring divider step
   assign rem2   = {rem_ff, 1'b0};
   assign div_ge = rem2 >= {1'b0, dur_ff};

   assign cond.neg      = el_sat[17];
   assign cond.full     = (dur_ff == '0) || (elapsed_ff[16:0] >= {1'b0, dur_ff});
   assign cond.div_more = count_ff != CNT_W'(1);

   // shared multiplier operands
   assign upper_half  = (mode_ff == EASE_QUAD_OUT) ||
                        ((mode_ff == EASE_QUAD_IN_OUT) && (t_ff >= HALF_FX));
   assign two_minus_t = TWO_FX - {1'b0, t_ff};
   assign diff_x = $signed({to_x_ff[VALUE_WIDTH-1], to_x_ff} - {from_x_ff[VALUE_WIDTH-1], from_x_ff});
   assign diff_y = $signed({to_y_ff[VALUE_WIDTH-1], to_y_ff} - {from_y_ff[VALUE_WIDTH-1], from_y_ff});

   always_comb begin
      mul_a = MA_W'({1'b0, t_ff});
      mul_b = MB_W'({1'b0, t_ff});
      case (cw.uop)
         UOP_EMUL: begin
            if (upper_half) mul_b = MB_W'(two_minus_t);
         end
         UOP_MULX: begin
            mul_a = MA_W'(diff_x);
            mul_b = MB_W'({1'b0, e_ff});
         end
         UOP_MULY: begin
            mul_a = MA_W'(diff_y);
            mul_b = MB_W'({1'b0, e_ff});
         end
         default: begin
            mul_a = MA_W'({1'b0, t_ff});
         end
      endcase
   end

   assign product  = PW'(mul_a) * PW'(mul_b);
   assign shaped   = (mode_ff == EASE_QUAD_IN_OUT) ? (prod_ff >>> (FRAC_BITS - 1))
                                                   : (prod_ff >>> FRAC_BITS);
   assign rounded  = prod_ff + $signed(RND);
   assign q_val    = rounded >>> FRAC_BITS;
   assign from_sel = (cw.uop == UOP_VALX) ? from_x_ff : from_y_ff;
   assign ep_wide  = {e_ff, 16'h0000} >> FRAC_BITS;

   always_ff @(posedge clock) begin
      if (running) begin
         case (cw.uop)
            UOP_ADD: begin
               dt_ff <= dt_ff;
            end
            UOP_CHECK: begin
               full_ff  <= cond.full;
               t_ff     <= cond.full ? ONE_FX : '0;
               rem_ff   <= elapsed_ff[15:0];
               count_ff <= CNT_W'(FRAC_BITS);
            end
            UOP_DIV: begin
               rem_ff   <= div_ge ? 16'(rem2 - {1'b0, dur_ff}) : rem2[15:0];
               t_ff     <= {t_ff[EW-2:0], div_ge};
               count_ff <= count_ff - 1'b1;
            end
            UOP_EMUL, UOP_MULX, UOP_MULY: begin
               prod_ff <= product;
            end
            UOP_SHAPE: begin
               if (mode_ff == EASE_LINEAR) begin
                  e_ff <= t_ff;
               end else if ((mode_ff == EASE_QUAD_IN_OUT) && (t_ff >= HALF_FX)) begin
                  e_ff <= shaped[EW-1:0] - ONE_FX;
               end else begin
                  e_ff <= shaped[EW-1:0];
               end
            end
            UOP_VALX: vx_ff <= from_sel + q_val[VALUE_WIDTH-1:0];
            UOP_VALY: vy_ff <= from_sel + q_val[VALUE_WIDTH-1:0];
            default: begin
               e_ff <= e_ff;
            end
         endcase
      end
      if (launch) dt_ff <= req_data.dt;
   end

   // flags, elapsed count and result word
   always_comb begin
      elapsed_in  = elapsed_ff;
      playing_in  = playing_ff;
      finished_in = finished_ff;
      rsp_load    = 1'b0;
      rsp_in      = '0;
      if (accept && !launch) begin
         rsp_load = 1'b1;
         case (req_data.op)
            OP_START: begin
               elapsed_in  = $signed(18'h00000 - {2'b00, delay_ff});
               playing_in  = 1'b1;
               finished_in = 1'b0;
            end
            OP_STOP: begin
               playing_in  = 1'b0;
               finished_in = 1'b1;
            end
            OP_PAUSE:  playing_in = 1'b0;
            OP_RESUME: begin
               if (!finished_ff) playing_in = 1'b1;
            end
            default:   playing_in = playing_ff;
         endcase
      end else if (running && (cw.uop == UOP_ADD)) begin
         elapsed_in = $signed(el_sat);
      end else if (running && (cw.uop == UOP_DONE) && !hold) begin
         rsp_load = 1'b1;
         if (applied_ff) begin
            rsp_in.value_x        = 16'(vx_ff);
            rsp_in.value_y        = 16'(vy_ff);
            rsp_in.applied        = 1'b1;
            rsp_in.eased_progress = ep_wide[16:0];
            if (full_ff) begin
               if (loop_ff) begin
                  elapsed_in = '0;
               end else begin
                  finished_in     = 1'b1;
                  playing_in      = 1'b0;
                  rsp_in.complete = 1'b1;
               end
            end
         end
      end
      rsp_in.playing  = playing_in;
      rsp_in.finished = finished_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff   <= '0;
         playing_ff   <= 1'b0;
         finished_ff  <= 1'b0;
         applied_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         elapsed_ff  <= elapsed_in;
         playing_ff  <= playing_in;
         finished_ff <= finished_in;
         if (running && (cw.uop == UOP_ADD)) applied_ff <= !cond.neg;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) rsp_ff <= rsp_in;
   end

   a_busy_blocks_input: assert property (@(posedge clock) disable iff (reset)
      running |-> !req_ready)
      else $error("input taken while a tick is in progress");

   a_complete_flags: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.complete) |-> (rsp_ff.finished && !rsp_ff.playing))
      else $error("complete without finished state");

   a_not_applied_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.applied) |->
      ((rsp_ff.value_x == '0) && (rsp_ff.value_y == '0) && (rsp_ff.eased_progress == '0)))
      else $error("values reported without applied");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_ff)))
      else $error("stalled result word changed");

endmodule
